[src/pvef_pkg.sv]
// ----------------------------------------------------------------------------
// pvef_pkg
// types and constants shared by the vertical prewitt edge filter files
// ----------------------------------------------------------------------------
`default_nettype none

package pvef_pkg;

  // input item: command plus one rgb pixel
  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       is_interior;
    logic       frame_last;
  } out_item_t;

  // packed pixel as held in the line stores and the window
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int CFG_AW = 3;

  // register reset values
  localparam logic [10:0] WIDTH_RESET  = 11'd320;
  localparam logic [11:0] HEIGHT_RESET = 12'd240;

  // floor(x / 3) == (x * 683) >> 11 for every x below 2048
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

endpackage : pvef_pkg

`default_nettype wire

[src/pvef_col_diff.sv]
// ----------------------------------------------------------------------------
// pvef_col_diff
// one channel of the vertical prewitt kernel: |right sum - left sum| / 3
// ----------------------------------------------------------------------------
`default_nettype none

module pvef_col_diff (
  input  logic [2:0][7:0] left_col,
  input  logic [2:0][7:0] right_col,
  output logic [7:0]      mag
);
  import pvef_pkg::*;

  logic        [9:0]  sum_l;
  logic        [9:0]  sum_r;
  logic signed [10:0] diff;
  logic        [9:0]  abs_diff;
  logic        [19:0] prod;

  assign sum_l = 10'(left_col[0]) + 10'(left_col[1]) + 10'(left_col[2]);
  assign sum_r = 10'(right_col[0]) + 10'(right_col[1]) + 10'(right_col[2]);
  assign diff  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});

  // magnitude is at most 765
  assign abs_diff = diff[10] ? 10'(-diff) : diff[9:0];

  // divide by three through the reciprocal, exact in this range
  assign prod = 20'(abs_diff) * 20'(DIV3_MUL);
  assign mag  = prod[DIV3_SHIFT +: 8];

endmodule : pvef_col_diff

`default_nettype wire

[src/prewitt_vertical_edge_filter.sv]
// ----------------------------------------------------------------------------
// prewitt_vertical_edge_filter
// vertical prewitt edge filter over a raster-order rgb pixel stream
// ----------------------------------------------------------------------------
//
//  channel  | ports                               | moves
//  ---------+-------------------------------------+---------------------------
//  input    | in_valid / in_ready / in_data       | one pixel or drain item
//  result   | out_valid / out_ready / out_data    | one filtered or border px
//  config   | psel penable pwrite paddr pwdata .. | image_width, image_height
//
//  one item per clock while in_ready is high; a taken item's result reaches
//  out_valid through the line store read, then the window / kernel stage
//  the two line stores are read at the item column and written back in the
//  following cycle; a back-to-back access to the same column is forwarded
//  the stores have no clearing pass: the block is ready right after reset
//  a two-item result queue absorbs out_ready stalls; in_ready drops only when
//  the queue and the item in flight would overfill it
//
`default_nettype none

module prewitt_vertical_edge_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pvef_pkg::in_item_t     in_data,
  // result items
  output logic                   out_valid,
  input  logic                   out_ready,
  output pvef_pkg::out_item_t    out_data,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [pvef_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import pvef_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);      // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);  // effective width

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // word decode only, byte lanes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {21'd0, width_r};
      REG_IMAGE_HEIGHT: prdata = {20'd0, height_r};
      default:          prdata = '0;
    endcase
  end

  // effective frame size: zero counts as one, width saturates at the store
  logic [WW-1:0] w_eff;
  logic [WW-1:0] w_last;
  logic [11:0]   h_eff;
  logic [11:0]   h_last;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff  = (height_r == 12'd0) ? 12'd1 : height_r;
    w_last = w_eff - WW'(1);
    h_last = h_eff - 12'd1;
  end

  // --------------------------------------------------------------------------
  // result queue (two items)
  // --------------------------------------------------------------------------
  out_item_t   fifo_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, deq;
  logic [1:0]  occ;

  logic        s1_v_r;
  logic        s1_emit_r;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rp_r];
  assign deq       = out_valid & out_ready;
  assign push      = s1_v_r & s1_emit_r;

  // room for the item in flight plus a new one, counting this cycle's pop
  assign occ      = cnt_r + 2'(s1_v_r);
  assign in_ready = (occ <= 2'd1) || ((occ == 2'd2) && deq);

  // --------------------------------------------------------------------------
  // stage 0: position tracking and store read
  // --------------------------------------------------------------------------
  logic [AW-1:0] ic_r;    // input column
  logic [12:0]   ir_r;    // input row, runs past the frame while draining
  logic [AW-1:0] opc_r;   // output column
  logic [11:0]   opr_r;   // output row

  logic          acc;
  logic          in_frame;
  logic          act;
  rgb_t          pix;
  logic          emit;
  logic          interior;
  logic          last;
  logic          in_col_end;
  logic          out_col_end;

  assign acc      = in_valid & in_ready;
  assign in_frame = (ir_r < {1'b0, h_eff});
  // drain before the frame is complete is dropped without effect
  assign act      = acc & ~(in_frame & (in_data.cmd == CMD_DRAIN));
  assign pix      = in_frame ? rgb_t'({in_data.red_in, in_data.green_in, in_data.blue_in})
                             : rgb_t'('0);

  // a result trails the input by one row and one pixel
  assign emit     = (ir_r >= 13'd2) || ((ir_r == 13'd1) && (ic_r != '0));
  assign interior = (opr_r != 12'd0) && (opr_r < h_last) &&
                    (opc_r != '0) && (WW'(opc_r) < w_last);
  assign last     = (opr_r == h_last) && (WW'(opc_r) == w_last);

  assign in_col_end  = (WW'(ic_r) == w_last);
  assign out_col_end = (WW'(opc_r) == w_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r  <= '0;
      ir_r  <= '0;
      opc_r <= '0;
      opr_r <= '0;
    end else if (cfg_wr) begin
      ic_r  <= '0;
      ir_r  <= '0;
      opc_r <= '0;
      opr_r <= '0;
    end else if (act) begin
      if (emit && last) begin
        // frame done, next item starts a new frame
        ic_r  <= '0;
        ir_r  <= '0;
        opc_r <= '0;
        opr_r <= '0;
      end else begin
        if (in_col_end) begin
          ic_r <= '0;
          ir_r <= ir_r + 13'd1;
        end else begin
          ic_r <= ic_r + AW'(1);
        end
        if (emit) begin
          if (out_col_end) begin
            opc_r <= '0;
            opr_r <= opr_r + 12'd1;
          end else begin
            opc_r <= opc_r + AW'(1);
          end
        end
      end
    end
  end

  // line stores, read old data on a same-cycle write
  rgb_t          upper_mem [MAX_WIDTH];
  rgb_t          lower_mem [MAX_WIDTH];
  rgb_t          up_q_r, lo_q_r;

  logic          s1_int_r, s1_last_r, s1_fwd_r;
  rgb_t          s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  rgb_t          fw_lo_r, fw_pix_r;
  rgb_t          up_cur, lo_cur;

  always_ff @(posedge clk) begin
    if (act) begin
      up_q_r <= upper_mem[ic_r];
      lo_q_r <= lower_mem[ic_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      upper_mem[s1_addr_r] <= lo_cur;
      lower_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_emit_r <= emit;
      s1_int_r  <= interior;
      s1_last_r <= last;
      s1_pix_r  <= pix;
      s1_addr_r <= ic_r;
      // the write in flight lands on the column just read (one-pixel rows)
      s1_fwd_r  <= s1_v_r && (s1_addr_r == ic_r);
    end
    if (s1_v_r) begin
      fw_lo_r  <= lo_cur;
      fw_pix_r <= s1_pix_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: window shift, kernel, store write back
  // --------------------------------------------------------------------------
  assign up_cur = s1_fwd_r ? fw_lo_r  : up_q_r;
  assign lo_cur = s1_fwd_r ? fw_pix_r : lo_q_r;

  // left, middle and right columns of the window; rows top, middle, bottom
  rgb_t c1_r [3];
  rgb_t c2_r [3];
  rgb_t right_col [3];
  rgb_t center;

  assign right_col[0] = up_cur;
  assign right_col[1] = lo_cur;
  assign right_col[2] = s1_pix_r;
  // after the shift the old middle column is the left one
  assign center       = c2_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        c1_r[i] <= '0;
        c2_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        c1_r[i] <= c2_r[i];
        c2_r[i] <= right_col[i];
      end
    end
  end

  logic [7:0] mag_r, mag_g, mag_b;

  pvef_col_diff u_diff_r (
    .left_col  ({c1_r[2].r, c1_r[1].r, c1_r[0].r}),
    .right_col ({right_col[2].r, right_col[1].r, right_col[0].r}),
    .mag       (mag_r)
  );

  pvef_col_diff u_diff_g (
    .left_col  ({c1_r[2].g, c1_r[1].g, c1_r[0].g}),
    .right_col ({right_col[2].g, right_col[1].g, right_col[0].g}),
    .mag       (mag_g)
  );

  pvef_col_diff u_diff_b (
    .left_col  ({c1_r[2].b, c1_r[1].b, c1_r[0].b}),
    .right_col ({right_col[2].b, right_col[1].b, right_col[0].b}),
    .mag       (mag_b)
  );

  out_item_t res;

  // border pixels pass the window center through
  always_comb begin
    res.red_out     = s1_int_r ? mag_r : center.r;
    res.green_out   = s1_int_r ? mag_g : center.g;
    res.blue_out    = s1_int_r ? mag_b : center.b;
    res.is_interior = s1_int_r;
    res.frame_last  = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (deq) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(deq);
    end
  end

endmodule : prewitt_vertical_edge_filter

`default_nettype wire

[src/pvef_checker.sv]
// ----------------------------------------------------------------------------
// pvef_checker
// port-level checks for the vertical prewitt edge filter
// ----------------------------------------------------------------------------
`default_nettype none

module pvef_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pvef_pkg::out_item_t out_data
);
  import pvef_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result from an empty queue needs an item taken ahead of the store read and kernel stages
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an item taken two cycles before");

  // last pixel of a frame sits in the right border column
  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_last |-> !out_data.is_interior)
    else $error("frame last marked interior");

endmodule : pvef_checker

bind prewitt_vertical_edge_filter pvef_checker u_pvef_checker (.*);

`default_nettype wire
